### sv/odf_pkg.sv
// Shared types and constants for the order-preserving duplicate filter.
// No dependencies; used by every other file of the filter.
package odf_pkg;

  localparam int unsigned VALUE_W = 31;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               is_first;
    logic               end_of_list;
    logic               table_full;
  } result_t;

endpackage

### sv/order_preserving_dedup_filter.sv
// Order-preserving duplicate filter: marks the first occurrence of each value in a list.
// Each input word is compared against the stored values by a scan of the table, one
// entry per cycle; no new word is taken until its result has gone to the output register.
// A duplicate found early ends the scan sooner.
// Synchronous reset empties the table by clearing the fill count; entries keep old data.
module order_preserving_dedup_filter #(
  parameter int unsigned SEEN_DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [odf_pkg::VALUE_W-1:0] value,
  input  logic                        last_in_list,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [odf_pkg::VALUE_W-1:0] value_out,
  output logic                        is_first,
  output logic                        end_of_list,
  output logic                        table_full
);

  localparam int unsigned IDX_W = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(SEEN_DEPTH + 1);

  logic                        rd_en;
  logic [IDX_W-1:0]            rd_addr;
  logic [odf_pkg::VALUE_W-1:0] rd_data;
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;
  logic [odf_pkg::VALUE_W-1:0] wr_data;
  logic                        res_valid;
  logic                        res_ready;
  odf_pkg::result_t            res;
  odf_pkg::result_t            out_word;

  odf_seen_mem #(
    .SEEN_DEPTH (SEEN_DEPTH),
    .IDX_W      (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  odf_scan_ctrl #(
    .SEEN_DEPTH (SEEN_DEPTH),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (value),
    .in_last   (last_in_list),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  odf_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (res_valid),
    .load_ready (res_ready),
    .load_word  (res),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

  assign value_out   = out_word.value;
  assign is_first    = out_word.is_first;
  assign end_of_list = out_word.end_of_list;
  assign table_full  = out_word.table_full;

  a_dup_not_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_first |-> !table_full)
    else $error("duplicate word reported with table_full set");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an accepted word");

  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word appeared without a scan in progress");

  a_write_only_new: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> res.is_first && !res.table_full && res_valid)
    else $error("table written for a duplicate or overflowing word");

endmodule

### sv/odf_seen_mem.sv
// Seen-value table: single write port and one registered read port.
// Depends on odf_pkg for the value width.
module odf_seen_mem #(
  parameter int unsigned SEEN_DEPTH = 256,
  parameter int unsigned IDX_W      = $clog2(SEEN_DEPTH)
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [IDX_W-1:0]            rd_addr,
  output logic [odf_pkg::VALUE_W-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [IDX_W-1:0]            wr_addr,
  input  logic [odf_pkg::VALUE_W-1:0] wr_data
);

  logic [odf_pkg::VALUE_W-1:0] mem [SEEN_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/odf_scan_ctrl.sv
// Scan controller: takes a word, walks the seen table one entry per cycle,
// then appends a new value and keeps the fill count. Depends on odf_pkg.
module odf_scan_ctrl #(
  parameter int unsigned SEEN_DEPTH = 256,
  parameter int unsigned IDX_W      = $clog2(SEEN_DEPTH),
  parameter int unsigned CNT_W      = $clog2(SEEN_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [odf_pkg::VALUE_W-1:0] in_value,
  input  logic                        in_last,
  output logic                        rd_en,
  output logic [IDX_W-1:0]            rd_addr,
  input  logic [odf_pkg::VALUE_W-1:0] rd_data,
  output logic                        wr_en,
  output logic [IDX_W-1:0]            wr_addr,
  output logic [odf_pkg::VALUE_W-1:0] wr_data,
  output logic                        res_valid,
  input  logic                        res_ready,
  output odf_pkg::result_t            res
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_RESULT = 3'b100
  } state_t;

  state_t                      state;
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            issue_idx;
  logic                        pend;
  logic [odf_pkg::VALUE_W-1:0] value_r;
  logic                        last_r;
  logic                        first_r;
  logic                        full_r;
  logic                        match;

  always_comb begin
    in_stall  = (state != ST_IDLE);
    rd_en     = (state == ST_SCAN) && (issue_idx < count);
    rd_addr   = issue_idx[IDX_W-1:0];
    match     = pend && (rd_data == value_r);
    res_valid = (state == ST_RESULT);
    res       = '{value: value_r, is_first: first_r, end_of_list: last_r, table_full: full_r};
    wr_en     = res_valid && res_ready && first_r && !full_r;
    wr_addr   = count[IDX_W-1:0];
    wr_data   = value_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            value_r   <= in_value;
            last_r    <= in_last;
            issue_idx <= '0;
            pend      <= 1'b0;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (match) begin
            first_r <= 1'b0;
            full_r  <= 1'b0;
            state   <= ST_RESULT;
          end else if (!rd_en) begin
            first_r <= 1'b1;
            full_r  <= (count == CNT_W'(SEEN_DEPTH));
            state   <= ST_RESULT;
          end else begin
            issue_idx <= issue_idx + CNT_W'(1);
            pend      <= 1'b1;
          end
        end
        ST_RESULT: begin
          if (res_ready) begin
            if (last_r) begin
              count <= '0;
            end else if (wr_en) begin
              count <= count + CNT_W'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### sv/odf_out_reg.sv
// Output register holding one result word until the consumer takes it.
// Depends on odf_pkg for the result word type.
module odf_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_valid,
  output logic             load_ready,
  input  odf_pkg::result_t load_word,
  output logic             out_valid,
  input  logic             out_stall,
  output odf_pkg::result_t out_word
);

  assign load_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ready) begin
      out_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      out_word <= load_word;
    end
  end

endmodule
